FILE: hdl/bba_pkg.sv
// Shared types, codes and constants of the bitmap block allocator.
`default_nettype none
package bba_pkg;

   localparam int NUM_WORDS_DEF = 4096;
   localparam int WORD_BITS     = 32;
   localparam int LO_W          = 5;

   localparam int KIND_W     = 2;
   localparam int FIRST_W    = 17;
   localparam int COUNT_W    = 18;
   localparam int STATUS_W   = 2;
   localparam int REGION_W   = 17;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [WORD_BITS-1:0] ALL_USED = 32'hFFFF_FFFF;

   localparam logic [KIND_W-1:0] KIND_MARK  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
   localparam logic [STATUS_W-1:0] ST_CONFLICT = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

   // register index taken from paddr[2]
   localparam logic CSR_CHECK_REG = 1'b0;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_PRIME,
      S_MARK,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] new_word;
      logic                 conflict;
      logic [COUNT_W-1:0]   left_next;
      logic                 run_broken;
      logic                 run_found;
      logic [COUNT_W-1:0]   need_next;
   } word_res_type;

endpackage
`default_nettype wire

FILE: hdl/bba_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module bba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                                 clock,
   input  wire logic                                 wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                     wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: hdl/bba_word_ops.sv
// Per-word mark/free update and free-run test on one bitmap word.
`default_nettype none
module bba_word_ops (
   input  wire logic [bba_pkg::WORD_BITS-1:0] word,
   input  wire logic [bba_pkg::LO_W-1:0]      lo,
   input  wire logic [bba_pkg::COUNT_W-1:0]   left,
   input  wire logic                          op_free,
   input  wire logic                          check,
   output bba_pkg::word_res_type              res
);

   logic [bba_pkg::LO_W:0]        span;
   logic                          to_end;
   logic [bba_pkg::LO_W-1:0]      end_pos;
   logic [bba_pkg::WORD_BITS-1:0] hi_mask;
   logic [bba_pkg::WORD_BITS-1:0] lo_mask;
   logic [bba_pkg::WORD_BITS-1:0] mask;
   logic [bba_pkg::WORD_BITS-1:0] hit;
   logic [bba_pkg::WORD_BITS-1:0] below;
   logic [bba_pkg::WORD_BITS-1:0] part;
   logic                          whole;
   logic                          big;
   logic [bba_pkg::WORD_BITS-1:0] need_mask;

   always_comb begin
      span    = (bba_pkg::LO_W+1)'(bba_pkg::WORD_BITS) - {1'b0, lo};
      to_end  = left >= bba_pkg::COUNT_W'(span);
      end_pos = lo + left[bba_pkg::LO_W-1:0];
      hi_mask = to_end ? bba_pkg::ALL_USED
                       : (bba_pkg::WORD_BITS'(1) << end_pos) - bba_pkg::WORD_BITS'(1);
      lo_mask = ~((bba_pkg::WORD_BITS'(1) << lo) - bba_pkg::WORD_BITS'(1));
      mask    = hi_mask & lo_mask;
      whole   = !op_free && (lo == '0) && (left >= bba_pkg::COUNT_W'(bba_pkg::WORD_BITS));
      hit     = op_free ? (~word & mask) : (word & mask);
      // bits below the lowest conflicting bit
      below   = ~hit & (hit - bba_pkg::WORD_BITS'(1));

      res.conflict = check && (hit != '0);
      if (res.conflict) begin
         part = whole ? '0 : (mask & below);
      end else begin
         part = mask;
      end
      res.new_word  = op_free ? (word & ~part) : (word | part);
      res.left_next = to_end ? (left - bba_pkg::COUNT_W'(span)) : '0;

      big       = left >= bba_pkg::COUNT_W'(bba_pkg::WORD_BITS);
      need_mask = (bba_pkg::WORD_BITS'(1) << left[bba_pkg::LO_W-1:0])
                  - bba_pkg::WORD_BITS'(1);
      res.need_next  = left - bba_pkg::COUNT_W'(bba_pkg::WORD_BITS);
      res.run_broken = big ? (word != '0) : ((word & need_mask) != '0);
      res.run_found  = !res.run_broken && (!big || (res.need_next == '0));
   end

endmodule
`default_nettype wire

FILE: hdl/bitmap_block_allocator.sv
// Bitmap block allocator top level: command sequencer, CSR port, result register.
//
// One command word is taken at a time and answered by one result word.
// After reset the bitmap memory is cleared one word per cycle, during which
// req_tready stays low. The bitmap memory has one read and one write port
// and is walked one word per cycle: a mark or free walks the bitmap words
// the range touches; an allocation first scans words until the free run is
// found (all NUM_WORDS when none fits) and then walks the words of the run.
// Commands rejected up front (range past the end, empty range, unknown kind)
// go from decode straight to the result. A new command is taken while the
// last result still waits in the output register.
`default_nettype none
module bitmap_block_allocator #(
   parameter int NUM_WORDS = bba_pkg::NUM_WORDS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // first_block[16:0], block_count[34:17], zero fill
   input  wire logic [bba_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind[1:0]
   input  wire logic [bba_pkg::KIND_W-1:0]        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // status[1:0], region_start[18:2], zero fill
   output logic      [bba_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [bba_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [bba_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [bba_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int AW   = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int SUMW = (AW + 6 > 19) ? AW + 6 : 19;
   localparam int TOTAL_BLOCKS = NUM_WORDS * bba_pkg::WORD_BITS;

   bba_pkg::state_type state_ff, state_in;

   logic [AW-1:0]                   clr_ff, clr_in;
   logic [bba_pkg::KIND_W-1:0]      kind_ff, kind_in;
   logic [bba_pkg::FIRST_W-1:0]     first_ff, first_in;
   logic [bba_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [AW-1:0]                   cur_w_ff, cur_w_in;
   logic [AW-1:0]                   start_ff, start_in;
   logic [bba_pkg::LO_W-1:0]        lo_ff, lo_in;
   logic [bba_pkg::COUNT_W-1:0]     left_ff, left_in;
   logic                            op_free_ff, op_free_in;
   logic [bba_pkg::STATUS_W-1:0]    status_ff, status_in;
   logic [bba_pkg::REGION_W-1:0]    region_ff, region_in;
   logic                            check_ff, check_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STATUS_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [bba_pkg::REGION_W-1:0]    rsp_region_ff, rsp_region_in;

   logic                            req_accept;
   logic                            csr_write;
   logic                            range_op;
   logic                            fits;
   logic                            last_word;
   logic                            handoff;

   logic                            ram_wr_en;
   logic [AW-1:0]                   ram_wr_addr;
   logic [bba_pkg::WORD_BITS-1:0]   ram_wr_data;
   logic [AW-1:0]                   ram_rd_addr;
   logic [bba_pkg::WORD_BITS-1:0]   ram_rd_data;

   bba_pkg::word_res_type           wres;

   bba_ram #(
      .WIDTH (bba_pkg::WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bba_word_ops u_word_ops (
      .word    (ram_rd_data),
      .lo      (lo_ff),
      .left    (left_ff),
      .op_free (op_free_ff),
      .check   (check_ff),
      .res     (wres)
   );

   assign req_accept = req_tvalid && req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[bba_pkg::CSR_ADDR_W-1] == bba_pkg::CSR_CHECK_REG)
                       ? bba_pkg::CSR_DATA_W'(check_ff) : '0;

   assign range_op  = (kind_ff == bba_pkg::KIND_MARK) || (kind_ff == bba_pkg::KIND_FREE);
   assign fits      = (SUMW'(first_ff) + SUMW'(count_ff)) <= SUMW'(TOTAL_BLOCKS);
   assign last_word = cur_w_ff == AW'(NUM_WORDS - 1);
   assign handoff   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = bba_pkg::RSP_DATA_W'({rsp_region_ff, rsp_status_ff});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bba_pkg::S_CLEAR: begin
            if (clr_ff == AW'(NUM_WORDS - 1)) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         bba_pkg::S_IDLE: begin
            if (req_accept) begin
               state_in = bba_pkg::S_DECODE;
            end
         end
         bba_pkg::S_DECODE: begin
            if (range_op) begin
               state_in = (fits && count_ff != '0) ? bba_pkg::S_MARK : bba_pkg::S_DONE;
            end else if (kind_ff == bba_pkg::KIND_ALLOC && count_ff != '0) begin
               state_in = bba_pkg::S_SCAN;
            end else begin
               state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_SCAN: begin
            if (wres.run_found) begin
               state_in = bba_pkg::S_PRIME;
            end else if (last_word) begin
               state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_PRIME: begin
            state_in = bba_pkg::S_MARK;
         end
         bba_pkg::S_MARK: begin
            if (wres.conflict || wres.left_next == '0) begin
               state_in = bba_pkg::S_DONE;
            end
         end
         bba_pkg::S_DONE: begin
            if (handoff) begin
               state_in = bba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::S_CLEAR;
         end
      endcase
   end

   // handshake and memory control
   always_comb begin
      req_tready  = 1'b0;
      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_w_ff;
      ram_wr_data = wres.new_word;
      ram_rd_addr = cur_w_ff + AW'(1);
      case (state_ff)
         bba_pkg::S_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            ram_wr_data = '0;
         end
         bba_pkg::S_IDLE: begin
            req_tready = 1'b1;
         end
         bba_pkg::S_DECODE: begin
            ram_rd_addr = range_op ? AW'(first_ff[bba_pkg::FIRST_W-1:bba_pkg::LO_W]) : '0;
         end
         bba_pkg::S_PRIME: begin
            ram_rd_addr = start_ff;
         end
         bba_pkg::S_MARK: begin
            ram_wr_en = 1'b1;
         end
         default: begin
            ram_wr_en = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      clr_in        = clr_ff;
      kind_in       = kind_ff;
      first_in      = first_ff;
      count_in      = count_ff;
      cur_w_in      = cur_w_ff;
      start_in      = start_ff;
      lo_in         = lo_ff;
      left_in       = left_ff;
      op_free_in    = op_free_ff;
      status_in     = status_ff;
      region_in     = region_ff;
      check_in      = check_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_region_in = rsp_region_ff;

      if (csr_write && csr_paddr[bba_pkg::CSR_ADDR_W-1] == bba_pkg::CSR_CHECK_REG) begin
         check_in = csr_pwdata[0];
      end

      case (state_ff)
         bba_pkg::S_CLEAR: begin
            clr_in = clr_ff + AW'(1);
         end
         bba_pkg::S_IDLE: begin
            if (req_accept) begin
               kind_in  = req_tuser;
               first_in = req_tdata[bba_pkg::FIRST_W-1:0];
               count_in = req_tdata[bba_pkg::FIRST_W +: bba_pkg::COUNT_W];
            end
         end
         bba_pkg::S_DECODE: begin
            status_in  = (range_op && !fits) ? bba_pkg::ST_RANGE : bba_pkg::ST_OK;
            region_in  = '0;
            cur_w_in   = range_op ? AW'(first_ff[bba_pkg::FIRST_W-1:bba_pkg::LO_W]) : '0;
            lo_in      = range_op ? first_ff[bba_pkg::LO_W-1:0] : '0;
            left_in    = count_ff;
            op_free_in = kind_ff == bba_pkg::KIND_FREE;
            start_in   = '0;
         end
         bba_pkg::S_SCAN: begin
            cur_w_in = cur_w_ff + AW'(1);
            if (wres.run_found) begin
               region_in  = bba_pkg::REGION_W'({start_ff, bba_pkg::LO_W'(0)});
               cur_w_in   = start_ff;
               lo_in      = '0;
               left_in    = count_ff;
               op_free_in = 1'b0;
            end else if (wres.run_broken) begin
               left_in  = count_ff;
               start_in = cur_w_ff + AW'(1);
            end else begin
               left_in = wres.need_next;
            end
            if (!wres.run_found && last_word) begin
               status_in = bba_pkg::ST_NOFIT;
            end
         end
         bba_pkg::S_MARK: begin
            cur_w_in = cur_w_ff + AW'(1);
            lo_in    = '0;
            left_in  = wres.left_next;
            if (wres.conflict) begin
               status_in = bba_pkg::ST_CONFLICT;
               region_in = '0;
            end
         end
         bba_pkg::S_DONE: begin
            if (handoff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_region_in = region_ff;
            end
         end
         default: begin
            clr_in = clr_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::S_CLEAR;
         clr_ff       <= '0;
         check_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         check_ff     <= check_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      first_ff      <= first_in;
      count_ff      <= count_in;
      cur_w_ff      <= cur_w_in;
      start_ff      <= start_in;
      lo_ff         <= lo_in;
      left_ff       <= left_in;
      op_free_ff    <= op_free_in;
      status_ff     <= status_in;
      region_ff     <= region_in;
      rsp_status_ff <= rsp_status_in;
      rsp_region_ff <= rsp_region_in;
   end

endmodule
`default_nettype wire

FILE: hdl/bba_checker.sv
// Port-level checks of the bitmap block allocator, bound to the top level.
`default_nettype none
module bba_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [bba_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // clearing pass keeps input closed right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("req_tready high right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result word changed");

   a_region_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != bba_pkg::ST_OK |-> rsp_tdata[18:2] == '0)
      else $error("region_start nonzero on failed command");

   a_region_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[6:2] == '0)
      else $error("region_start not on a word boundary");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (.*);
`default_nettype wire

FILE: tb/sv/tb_bitmap_block_allocator.sv
// Testbench for the bitmap block allocator: random commands checked against a predictor.
module tb_bitmap_block_allocator;

   localparam int NW = bba_pkg::NUM_WORDS_DEF;
   localparam int STORE_BLOCKS = NW * bba_pkg::WORD_BITS;
   localparam logic [bba_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
   localparam int PHASES = 12;
   localparam int PHASE_CMDS = 100;
   localparam int DRAIN_CYCLES = 64;

   typedef struct packed {
      logic [bba_pkg::KIND_W-1:0]  kind;
      logic [bba_pkg::COUNT_W-1:0] count;
      logic [bba_pkg::FIRST_W-1:0] first;
   } alloc_cmd_type;

   typedef struct packed {
      logic [bba_pkg::REGION_W-1:0] region;
      logic [bba_pkg::STATUS_W-1:0] status;
   } alloc_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // first_block[16:0], block_count[34:17], zero fill
   logic [bba_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [bba_pkg::KIND_W-1:0] req_tuser = '0;       // kind[1:0]
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // status[1:0], region_start[18:2], zero fill
   logic [bba_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [bba_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [bba_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [bba_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   logic [bba_pkg::WORD_BITS-1:0] block_map [NW];
   logic conflict_check = 1'b0;

   alloc_cmd_type pending_cmds[$];
   alloc_result_type expected_results[$];
   alloc_cmd_type cur_cmd;
   int cmds_issued = 0;
   int results_checked = 0;
   int mismatches = 0;
   int req_gap = 0;
   int rsp_stall = 0;
   bit req_done = 1'b0;
   bit rsp_done = 1'b0;
   bit no_idle = 1'b0;

   bitmap_block_allocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      for (int i = 0; i < NW; i++) block_map[i] = '0;
   end

   function automatic logic [bba_pkg::STATUS_W-1:0] mark_blocks(int blk, int left);
      int w;
      int b;
      while (left > 0) begin
         w = blk / bba_pkg::WORD_BITS;
         b = blk % bba_pkg::WORD_BITS;
         if (w >= NW) return bba_pkg::ST_RANGE;
         if (left >= bba_pkg::WORD_BITS && b == 0) begin
            if (conflict_check && block_map[w] != '0) return bba_pkg::ST_CONFLICT;
            block_map[w] = bba_pkg::ALL_USED;
            blk += bba_pkg::WORD_BITS;
            left -= bba_pkg::WORD_BITS;
         end else begin
            if (conflict_check && block_map[w][b]) return bba_pkg::ST_CONFLICT;
            block_map[w][b] = 1'b1;
            blk++;
            left--;
         end
      end
      return bba_pkg::ST_OK;
   endfunction

   function automatic logic [bba_pkg::STATUS_W-1:0] free_blocks(int blk, int left);
      int w;
      int b;
      while (left > 0) begin
         w = blk / bba_pkg::WORD_BITS;
         b = blk % bba_pkg::WORD_BITS;
         if (w >= NW) return bba_pkg::ST_RANGE;
         if (conflict_check && !block_map[w][b]) return bba_pkg::ST_CONFLICT;
         block_map[w][b] = 1'b0;
         blk++;
         left--;
      end
      return bba_pkg::ST_OK;
   endfunction

   // first fit over word-aligned runs; a short tail only needs the low bits of its word
   function automatic bit find_free_run(int count, output int start_word);
      int need;
      logic [bba_pkg::WORD_BITS-1:0] mask;
      need = count;
      start_word = 0;
      if (count == 0) return 1'b1;
      for (int i = 0; i < NW; i++) begin
         if (need >= bba_pkg::WORD_BITS) begin
            if (block_map[i] != '0) begin
               need = count;
               start_word = i + 1;
            end else begin
               need -= bba_pkg::WORD_BITS;
               if (need == 0) return 1'b1;
            end
         end else begin
            mask = (32'd1 << need) - 32'd1;
            if ((block_map[i] & mask) != '0) begin
               need = count;
               start_word = i + 1;
            end else begin
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic alloc_result_type predict_result(alloc_cmd_type c);
      alloc_result_type r;
      int first;
      int count;
      int sw;
      r.status = bba_pkg::ST_OK;
      r.region = '0;
      first = int'(c.first);
      count = int'(c.count);
      if (c.kind == bba_pkg::KIND_MARK || c.kind == bba_pkg::KIND_FREE) begin
         if (first + count > STORE_BLOCKS) r.status = bba_pkg::ST_RANGE;
         else if (c.kind == bba_pkg::KIND_MARK) r.status = mark_blocks(first, count);
         else r.status = free_blocks(first, count);
      end else if (c.kind == bba_pkg::KIND_ALLOC) begin
         if (!find_free_run(count, sw)) begin
            r.status = bba_pkg::ST_NOFIT;
         end else begin
            r.status = mark_blocks(sw * bba_pkg::WORD_BITS, count);
            if (r.status == bba_pkg::ST_OK)
               r.region = bba_pkg::REGION_W'(sw * bba_pkg::WORD_BITS);
         end
      end
      return r;
   endfunction

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at result word %0d: %s expected %0d, got %0d",
                  results_checked, what, want, got);
   endtask

   // command driver
   always @(negedge clock) begin
      if (!reset && (!req_tvalid || req_done)) begin
         req_done = 1'b0;
         if (req_gap != 0 || pending_cmds.size() == 0) begin
            req_tvalid <= 1'b0;
            if (req_gap != 0) req_gap--;
         end else begin
            cur_cmd = pending_cmds.pop_front();
            req_tdata <= bba_pkg::REQ_DATA_W'({cur_cmd.count, cur_cmd.first});
            req_tuser <= cur_cmd.kind;
            req_tvalid <= 1'b1;
            req_gap = no_idle ? 0 : $urandom_range(0, 3);
         end
      end
   end

   // result back-pressure
   always @(negedge clock) begin
      if (rsp_done) begin
         rsp_done = 1'b0;
         rsp_stall = no_idle ? 0 : $urandom_range(0, 3);
      end
      if (reset || rsp_stall != 0) begin
         rsp_tready <= 1'b0;
         if (rsp_stall != 0) rsp_stall--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      alloc_result_type got;
      alloc_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsp_done = 1'b1;
            got = rsp_tdata[bba_pkg::STATUS_W+bba_pkg::REGION_W-1:0];
            if (expected_results.size() == 0) begin
               flag_mismatch("unexpected word, status", -1, int'(got.status));
            end else begin
               want = expected_results.pop_front();
               if (got.status !== want.status)
                  flag_mismatch("status", int'(want.status), int'(got.status));
               if (got.region !== want.region)
                  flag_mismatch("region_start", int'(want.region), int'(got.region));
               results_checked++;
            end
         end
         if (req_tvalid && req_tready) begin
            req_done = 1'b1;
            expected_results.push_back(predict_result(cur_cmd));
         end
      end
   end

   task automatic write_check(input logic value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {bba_pkg::CSR_CHECK_REG, 2'b00};
      csr_pwdata <= bba_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      conflict_check = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic push_cmd(input logic [bba_pkg::KIND_W-1:0] kind, input int first,
                           input int count);
      alloc_cmd_type c;
      c.kind = kind;
      c.first = bba_pkg::FIRST_W'(first);
      c.count = bba_pkg::COUNT_W'(count);
      pending_cmds.push_back(c);
      cmds_issued++;
   endtask

   task automatic wait_drained();
      while (results_checked < cmds_issued) @(negedge clock);
   endtask

   // mostly small ranges low in the store; a heavy command closes each phase
   task automatic push_random_cmd(input bit heavy);
      int sel;
      int first;
      int count;
      logic [bba_pkg::KIND_W-1:0] kind;
      sel = $urandom_range(0, 99);
      first = $urandom_range(0, 4095);
      count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 72);
      kind = ($urandom_range(0, 1) == 0) ? bba_pkg::KIND_MARK : bba_pkg::KIND_FREE;
      if (heavy) begin
         if (sel < 34) begin
            kind = bba_pkg::KIND_ALLOC;
            count = $urandom_range(1024, STORE_BLOCKS);
         end else begin
            first = $urandom_range(0, 127) * bba_pkg::WORD_BITS;
            count = $urandom_range(4096, STORE_BLOCKS - first);
         end
      end else if (sel < 60) begin
         if (sel < 20) first = first & ~(bba_pkg::WORD_BITS - 1);
      end else if (sel < 88) begin
         kind = bba_pkg::KIND_ALLOC;
      end else if (sel < 93) begin
         first = $urandom_range(0, STORE_BLOCKS - 1);
         count = $urandom_range(0, 40);
      end else if (sel < 97) begin
         first = $urandom_range(1, STORE_BLOCKS - 1);
         count = $urandom_range(STORE_BLOCKS - first + 1, STORE_BLOCKS);
      end else begin
         kind = KIND_NONE;
         first = $urandom_range(0, STORE_BLOCKS - 1);
         count = $urandom_range(0, STORE_BLOCKS);
      end
      push_cmd(kind, first, count);
   endtask

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (!req_tready) @(negedge clock);

      write_check(1'b0);
      push_cmd(bba_pkg::KIND_ALLOC, 0, 0);
      push_cmd(bba_pkg::KIND_MARK, 0, 0);
      push_cmd(bba_pkg::KIND_FREE, STORE_BLOCKS - 1, 0);
      push_cmd(KIND_NONE, STORE_BLOCKS - 1, STORE_BLOCKS);
      push_cmd(bba_pkg::KIND_MARK, STORE_BLOCKS - 1, 1);
      push_cmd(bba_pkg::KIND_MARK, STORE_BLOCKS - 1, 2);
      push_cmd(bba_pkg::KIND_FREE, 1, STORE_BLOCKS);
      push_cmd(bba_pkg::KIND_MARK, 0, STORE_BLOCKS);
      push_cmd(bba_pkg::KIND_ALLOC, 0, 1);
      push_cmd(bba_pkg::KIND_FREE, 0, STORE_BLOCKS);
      push_cmd(bba_pkg::KIND_ALLOC, 0, STORE_BLOCKS);
      push_cmd(bba_pkg::KIND_FREE, STORE_BLOCKS - 1024, 1024);
      push_cmd(bba_pkg::KIND_ALLOC, 0, 1024);
      push_cmd(bba_pkg::KIND_ALLOC, 0, 32);
      push_cmd(bba_pkg::KIND_FREE, 0, STORE_BLOCKS);
      push_cmd(bba_pkg::KIND_MARK, 3, 70);
      push_cmd(bba_pkg::KIND_ALLOC, 0, 40);
      push_cmd(bba_pkg::KIND_ALLOC, 0, 5);
      push_cmd(bba_pkg::KIND_FREE, 0, STORE_BLOCKS);
      wait_drained();

      write_check(1'b1);
      push_cmd(bba_pkg::KIND_MARK, 0, 64);
      push_cmd(bba_pkg::KIND_MARK, 32, 10);
      push_cmd(bba_pkg::KIND_MARK, 100, 1);
      push_cmd(bba_pkg::KIND_MARK, 96, 40);
      push_cmd(bba_pkg::KIND_FREE, 200, 5);
      push_cmd(bba_pkg::KIND_FREE, 0, 64);
      push_cmd(bba_pkg::KIND_FREE, 0, 1);
      push_cmd(bba_pkg::KIND_MARK, STORE_BLOCKS - bba_pkg::WORD_BITS, bba_pkg::WORD_BITS);
      push_cmd(bba_pkg::KIND_FREE, STORE_BLOCKS - bba_pkg::WORD_BITS - 1,
               bba_pkg::WORD_BITS + 2);

      for (int p = 0; p < PHASES; p++) begin
         wait_drained();
         write_check(1'b0);
         push_cmd(bba_pkg::KIND_FREE, 0, STORE_BLOCKS);
         wait_drained();
         write_check((p % 2) == 0);
         for (int n = 0; n < PHASE_CMDS; n++) begin
            if (n % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
            push_random_cmd(1'b0);
         end
         push_random_cmd(1'b1);
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

FILE: sim.f
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/bba_word_ops.sv
hdl/bitmap_block_allocator.sv
hdl/bba_checker.sv
tb/sv/tb_bitmap_block_allocator.sv
